// ===== rtl/dric_pkg.sv =====
// Package with widths, beat types and result types for the depth run interval caller.
package dric_pkg;

  localparam int unsigned POS_BITS   = 31;
  localparam int unsigned DEPTH_BITS = 24;
  localparam int unsigned SEQ_BITS   = 16;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [DEPTH_BITS-1:0] CUTOFF_RESET = DEPTH_BITS'(1);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FLUSH  = 1'b1
  } command_e;

  typedef enum logic {
    STRAND_FWD = 1'b0,
    STRAND_REV = 1'b1
  } strand_e;

  typedef struct packed {
    logic                  command;
    logic [SEQ_BITS-1:0]   sequence_id;
    logic [POS_BITS-1:0]   position;
    logic [DEPTH_BITS-1:0] depth_forward;
    logic [DEPTH_BITS-1:0] depth_reverse;
  } sample_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] sequence_id;
    logic                strand;
    logic [POS_BITS-1:0] interval_start;
    logic [POS_BITS-1:0] interval_end;
    logic                last;
  } interval_t;

endpackage

// ===== rtl/dric_sample_if.sv =====
// Handshake interface carrying depth samples and flush commands.
interface dric_sample_if import dric_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [SEQ_BITS-1:0]   sequence_id;
  logic [POS_BITS-1:0]   position;
  logic [DEPTH_BITS-1:0] depth_forward;
  logic [DEPTH_BITS-1:0] depth_reverse;

  modport source (
    output valid, command, sequence_id, position, depth_forward, depth_reverse,
    input  ready
  );
  modport sink (
    input  valid, command, sequence_id, position, depth_forward, depth_reverse,
    output ready
  );
endinterface

// ===== rtl/dric_interval_if.sv =====
// Handshake interface carrying emitted run intervals.
interface dric_interval_if import dric_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEQ_BITS-1:0] sequence_id_out;
  logic                strand;
  logic [POS_BITS-1:0] interval_start;
  logic [POS_BITS-1:0] interval_end;
  logic                last;

  modport source (
    output valid, sequence_id_out, strand, interval_start, interval_end, last,
    input  ready
  );
  modport sink (
    input  valid, sequence_id_out, strand, interval_start, interval_end, last,
    output ready
  );
endinterface

// ===== rtl/depth_run_interval_caller_core.sv =====
// Top level of the depth run interval caller: sample stage, run state and result queue.
//
//   port        dir  kind        payload
//   in_i        in   valid/ready command, sequence_id, position, depth_forward, depth_reverse
//   out_o       out  valid/ready sequence_id_out, strand, interval_start, interval_end, last
//   cfg_we_i    in   write       cfg_data_i -> cutoff_q
//
// An accepted beat is registered in the sample stage, is evaluated there and its zero,
// one or two intervals enter a four-entry result queue; the first can leave in the cycle after the evaluation.
// The single result port sets the rate: one beat per cycle while the output is ready and beats
// make at most one interval; while each makes two, the stage waits on the result port.
// Reset clears the runs, the current sequence, the stage and the queue; the cutoff is 1.
// A stalled output fills the queue; the stage waits for two free entries, or one and a pop.
module depth_run_interval_caller_core import dric_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DEPTH_BITS-1:0] cfg_data_i,
  dric_sample_if.sink           in_i,
  dric_interval_if.source       out_o
);

  logic [DEPTH_BITS-1:0] cutoff_q;

  logic    stage_v_q, stage_v_d;
  sample_t stage_q;

  logic [POS_BITS-1:0] start_q [2];
  logic [POS_BITS-1:0] end_q   [2];
  logic [POS_BITS-1:0] start_d [2];
  logic [POS_BITS-1:0] end_d   [2];
  logic [SEQ_BITS-1:0] cur_seq_q, cur_seq_d;

  interval_t           fifo_mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]  count_q;

  logic                  in_fire, pop, advance, counting, seq_changed;
  logic [DEPTH_BITS-1:0] dep [2];
  logic [1:0]            open, gap, low;
  logic [3:0]            flag;
  interval_t             cand [4];
  interval_t             res0, res1;
  logic [1:0]            n_res;

  assign in_fire = in_i.valid && in_i.ready;
  assign pop     = out_o.valid && out_o.ready;

  // Two free entries, or one plus a pop in the same cycle, are needed before the staged beat is evaluated.
  assign advance = stage_v_q &&
                   ((count_q <= FIFO_CW'(FIFO_DEPTH - 2)) ||
                    ((count_q == FIFO_CW'(FIFO_DEPTH - 1)) && pop));
  assign in_i.ready = !stage_v_q || advance;
  assign stage_v_d  = in_fire || (stage_v_q && !advance);

  assign dep[0] = stage_q.depth_forward;
  assign dep[1] = stage_q.depth_reverse;

  assign counting = (stage_q.command == CMD_SAMPLE) &&
                    (stage_q.position != '0) &&
                    ((dep[0] > cutoff_q) || (dep[1] > cutoff_q));
  assign seq_changed = stage_q.sequence_id != cur_seq_q;

  always_comb begin
    logic [POS_BITS:0] end_inc;
    for (int s = 0; s < 2; s++) begin
      end_inc = {1'b0, end_q[s]} + (POS_BITS + 1)'(1);
      open[s] = end_q[s] != '0;
      if (stage_q.command == CMD_FLUSH) begin
        gap[s] = open[s];
      end else begin
        gap[s] = counting && open[s] &&
                 (seq_changed || ({1'b0, stage_q.position} != end_inc));
      end
      low[s] = counting && open[s] && !gap[s] && (dep[s] < cutoff_q);
    end
  end

  // Candidates in emission order: both gap closes, then both low-depth closes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cand[i].strand         = (i % 2 == 0) ? STRAND_FWD : STRAND_REV;
      cand[i].interval_start = start_q[i % 2];
      cand[i].interval_end   = end_q[i % 2];
      cand[i].sequence_id    = (i < 2) ? cur_seq_q : stage_q.sequence_id;
      cand[i].last           = 1'b0;
    end
    flag = {low[1], low[0], gap[1], gap[0]};
  end

  always_comb begin
    logic [1:0] n;
    n    = '0;
    res0 = cand[0];
    res1 = cand[0];
    for (int i = 0; i < 4; i++) begin
      if (flag[i]) begin
        if (n == 2'd0) begin
          res0 = cand[i];
        end else begin
          res1 = cand[i];
        end
        n = n + 2'd1;
      end
    end
    res0.last = (n == 2'd1);
    res1.last = 1'b1;
    n_res     = advance ? n : 2'd0;
  end

  always_comb begin
    cur_seq_d = cur_seq_q;
    for (int s = 0; s < 2; s++) begin
      start_d[s] = start_q[s];
      end_d[s]   = end_q[s];
      if (advance) begin
        if (stage_q.command == CMD_FLUSH) begin
          start_d[s] = '0;
          end_d[s]   = '0;
        end else if (counting) begin
          if (dep[s] < cutoff_q) begin
            start_d[s] = '0;
            end_d[s]   = '0;
          end else if (!open[s] || gap[s]) begin
            start_d[s] = stage_q.position - POS_BITS'(1);
            end_d[s]   = stage_q.position;
          end else begin
            end_d[s]   = stage_q.position;
          end
        end
      end
    end
    if (advance && counting) begin
      cur_seq_d = stage_q.sequence_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q  <= CUTOFF_RESET;
      stage_v_q <= 1'b0;
      cur_seq_q <= '0;
      for (int s = 0; s < 2; s++) begin
        start_q[s] <= '0;
        end_q[s]   <= '0;
      end
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cutoff_q <= cfg_data_i;
      end
      stage_v_q <= stage_v_d;
      cur_seq_q <= cur_seq_d;
      for (int s = 0; s < 2; s++) begin
        start_q[s] <= start_d[s];
        end_q[s]   <= end_d[s];
      end
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_res);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      count_q <= count_q + FIFO_CW'(n_res) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_q.command       <= in_i.command;
      stage_q.sequence_id   <= in_i.sequence_id;
      stage_q.position      <= in_i.position;
      stage_q.depth_forward <= in_i.depth_forward;
      stage_q.depth_reverse <= in_i.depth_reverse;
    end
    if (n_res != 2'd0) begin
      fifo_mem_q[wr_ptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_mem_q[wr_ptr_q + FIFO_AW'(1)] <= res1;
    end
  end

  assign out_o.valid           = count_q != '0;
  assign out_o.sequence_id_out = fifo_mem_q[rd_ptr_q].sequence_id;
  assign out_o.strand          = fifo_mem_q[rd_ptr_q].strand;
  assign out_o.interval_start  = fifo_mem_q[rd_ptr_q].interval_start;
  assign out_o.interval_end    = fifo_mem_q[rd_ptr_q].interval_end;
  assign out_o.last            = fifo_mem_q[rd_ptr_q].last;

endmodule

// ===== tb/tb_depth_run_interval_caller_core.sv =====
// Self-checking testbench for the depth run interval caller: directed table, random windows.
module tb_depth_run_interval_caller_core;
  import dric_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};
  localparam int                    SETTLE    = 8;
  localparam int                    LONG_HOLD = 300;

  typedef enum logic {
    ROW_BEAT,
    ROW_CUTOFF
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    sample_t               beat;
    logic [DEPTH_BITS-1:0] cutoff;
    int                    n_typed;
    interval_t             exp0;
    interval_t             exp1;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [DEPTH_BITS-1:0] cfg_data;

  dric_sample_if   sif ();
  dric_interval_if rif ();

  depth_run_interval_caller_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (sif),
    .out_o      (rif)
  );

  always #5 clk_i = ~clk_i;

  // Run tracker state: one half-open run per strand, a zero end means no open run.
  logic [POS_BITS-1:0]   run_lo [2];
  logic [POS_BITS-1:0]   run_hi [2];
  logic [SEQ_BITS-1:0]   open_seq;
  logic [DEPTH_BITS-1:0] depth_cut;

  interval_t  interval_q [$];
  stim_row_t  rows [$];

  // Random window generator state.
  logic [POS_BITS-1:0] gen_pos;
  logic [SEQ_BITS-1:0] gen_seq;

  bit calm;
  bit hold_req;
  bit src_bursty;
  int src_mode_left;
  int stall_left;
  int burst_left;
  int sink_mode_left;
  bit sink_bursty;

  int n_fail;
  int n_beats;
  int n_flush;
  int n_cutoffs;
  int n_intervals;

  function automatic interval_t close_run(input int s);
    interval_t iv;
    iv.sequence_id    = open_seq;
    iv.strand         = (s == 1) ? STRAND_REV : STRAND_FWD;
    iv.interval_start = run_lo[s];
    iv.interval_end   = run_hi[s];
    iv.last           = 1'b0;
    run_lo[s] = '0;
    run_hi[s] = '0;
    return iv;
  endfunction

  function automatic void advance_runs(input sample_t b, output interval_t res [2],
                                       output int n);
    logic                  seq_moved;
    logic [DEPTH_BITS-1:0] dep;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (b.command == CMD_FLUSH) begin
      for (int s = 0; s < 2; s++) begin
        if (run_hi[s] != 0) begin
          res[n] = close_run(s);
          n++;
        end
      end
    end else if (b.position != 0 &&
                 (b.depth_forward > depth_cut || b.depth_reverse > depth_cut)) begin
      seq_moved = (b.sequence_id != open_seq);
      // Gap closes use the sequence of the run, so they come before the update.
      for (int s = 0; s < 2; s++) begin
        if (run_hi[s] != 0 &&
            (seq_moved || {1'b0, b.position} != {1'b0, run_hi[s]} + 32'd1)) begin
          res[n] = close_run(s);
          n++;
        end
      end
      open_seq = b.sequence_id;
      for (int s = 0; s < 2; s++) begin
        dep = (s == 1) ? b.depth_reverse : b.depth_forward;
        if (dep < depth_cut) begin
          if (run_hi[s] != 0) begin
            res[n] = close_run(s);
            n++;
          end
        end else if (run_hi[s] == 0) begin
          run_lo[s] = b.position - 1'b1;
          run_hi[s] = b.position;
        end else begin
          run_hi[s] = b.position;
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
  endfunction

  function automatic interval_t mk_iv(input logic [SEQ_BITS-1:0] seq, input logic strand,
                                      input logic [POS_BITS-1:0] lo, input logic [POS_BITS-1:0] hi,
                                      input logic last);
    interval_t iv;
    iv.sequence_id    = seq;
    iv.strand         = strand;
    iv.interval_start = lo;
    iv.interval_end   = hi;
    iv.last           = last;
    return iv;
  endfunction

  task automatic add_beat(input logic cmd, input logic [SEQ_BITS-1:0] seq,
                          input logic [POS_BITS-1:0] pos, input logic [DEPTH_BITS-1:0] df,
                          input logic [DEPTH_BITS-1:0] dr, input int n_typed = -1,
                          input interval_t e0 = '0, input interval_t e1 = '0);
    stim_row_t r;
    r.kind                 = ROW_BEAT;
    r.beat.command         = cmd;
    r.beat.sequence_id     = seq;
    r.beat.position        = pos;
    r.beat.depth_forward   = df;
    r.beat.depth_reverse   = dr;
    r.cutoff               = '0;
    r.n_typed              = n_typed;
    r.exp0                 = e0;
    r.exp1                 = e1;
    rows.push_back(r);
  endtask

  task automatic add_cutoff(input logic [DEPTH_BITS-1:0] value);
    stim_row_t r;
    r.kind    = ROW_CUTOFF;
    r.beat    = '0;
    r.cutoff  = value;
    r.n_typed = 0;
    r.exp0    = '0;
    r.exp1    = '0;
    rows.push_back(r);
  endtask

  function automatic logic [DEPTH_BITS-1:0] pick_depth();
    logic [31:0] sum;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DEPTH_MAX;
      2: return depth_cut;
      3: return (depth_cut == DEPTH_MAX) ? DEPTH_MAX : depth_cut + 1'b1;
      4: return (depth_cut == 0) ? '0 : depth_cut - 1'b1;
      5: return DEPTH_BITS'($urandom());
      default: begin
        sum = {8'b0, depth_cut} + $urandom_range(1, 100);
        return (sum > {8'b0, DEPTH_MAX}) ? DEPTH_MAX : sum[DEPTH_BITS-1:0];
      end
    endcase
  endfunction

  // Mostly consecutive positions inside a window, with gaps, repeats, jumps and noise mixed in.
  function automatic sample_t random_beat();
    sample_t b;
    int      r;
    b.command       = CMD_SAMPLE;
    b.sequence_id   = gen_seq;
    b.depth_forward = pick_depth();
    b.depth_reverse = pick_depth();
    r = $urandom_range(0, 39);
    if (r < 2) begin
      b.command     = CMD_FLUSH;
      b.sequence_id = SEQ_BITS'($urandom());
      b.position    = POS_BITS'($urandom());
      return b;
    end
    if (r < 28) begin
      b.position = (gen_pos == POS_MAX) ? POS_BITS'(1) : gen_pos + 1'b1;
    end else if (r < 31) begin
      b.position = (gen_pos > POS_MAX - 64) ? POS_BITS'(1)
                                            : gen_pos + POS_BITS'($urandom_range(2, 60));
    end else if (r < 33) begin
      b.position = (gen_pos > 3) ? gen_pos - POS_BITS'($urandom_range(0, 3)) : gen_pos;
    end else if (r == 33) begin
      b.position = '0;
    end else if (r == 34) begin
      b.position = POS_BITS'($urandom());
    end else if (r == 35) begin
      b.position = POS_MAX - POS_BITS'($urandom_range(0, 4));
    end else if (r < 38) begin
      gen_seq       = $urandom_range(0, 1) ? SEQ_BITS'($urandom())
                                           : SEQ_BITS'($urandom_range(0, 3));
      b.sequence_id = gen_seq;
      b.position    = POS_BITS'($urandom_range(1, 200));
    end else begin
      b.sequence_id   = SEQ_BITS'($urandom());
      b.position      = POS_BITS'($urandom());
      b.depth_forward = DEPTH_BITS'($urandom());
      b.depth_reverse = DEPTH_BITS'($urandom());
    end
    if (b.position != 0) gen_pos = b.position;
    return b;
  endfunction

  // Offers one beat, waits for its acceptance and records the intervals it must produce.
  task automatic send_beat(input sample_t b, input int n_typed, input interval_t e0,
                           input interval_t e1);
    interval_t res [2];
    int        n;
    @(negedge clk_i);
    if (src_mode_left == 0) begin
      src_bursty    = !calm && $urandom_range(0, 2) != 0;
      src_mode_left = $urandom_range(5, 60);
    end
    src_mode_left--;
    if (src_bursty && !calm && $urandom_range(0, 4) == 0) begin
      sif.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    sif.valid         = 1'b1;
    sif.command       = b.command;
    sif.sequence_id   = b.sequence_id;
    sif.position      = b.position;
    sif.depth_forward = b.depth_forward;
    sif.depth_reverse = b.depth_reverse;
    do @(posedge clk_i); while (!sif.ready);
    advance_runs(b, res, n);
    if (n_typed < 0) begin
      for (int k = 0; k < n; k++) interval_q.push_back(res[k]);
    end else begin
      if (n_typed > 0) interval_q.push_back(e0);
      if (n_typed > 1) interval_q.push_back(e1);
    end
    n_beats++;
    if (b.command == CMD_FLUSH) n_flush++;
  endtask

  task automatic drain(input bit settle);
    @(negedge clk_i);
    sif.valid = 1'b0;
    while (interval_q.size() != 0) @(posedge clk_i);
    // A beat that makes no interval may still sit in the sample stage.
    if (settle) repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_cutoff(input logic [DEPTH_BITS-1:0] value);
    drain(1'b1);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    depth_cut = value;
    n_cutoffs++;
  endtask

  // Result side: random ready bursts, a long hold-off on request, none in the final phase.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (sink_mode_left == 0) begin
      sink_bursty    = $urandom_range(0, 2) != 0;
      sink_mode_left = $urandom_range(20, 120);
    end
    sink_mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      rif.ready = 1'b0;
    end else if (calm || !sink_bursty) begin
      burst_left = 0;
      rif.ready  = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      rif.ready = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(1, 14) - 1;
      rif.ready  = 1'b0;
    end else begin
      rif.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    interval_t want;
    if (rst_ni && rif.valid && rif.ready) begin
      if (interval_q.size() == 0) begin
        $error("unexpected interval: seq %0h strand %0d [%0d,%0d) last %0d",
               rif.sequence_id_out, rif.strand, rif.interval_start, rif.interval_end, rif.last);
        n_fail++;
      end else begin
        want = interval_q.pop_front();
        n_intervals++;
        if (rif.sequence_id_out !== want.sequence_id) begin
          $error("sequence_id_out: expected %0h, got %0h", want.sequence_id, rif.sequence_id_out);
          n_fail++;
        end
        if (rif.strand !== want.strand) begin
          $error("strand: expected %0d, got %0d", want.strand, rif.strand);
          n_fail++;
        end
        if (rif.interval_start !== want.interval_start) begin
          $error("interval_start: expected %0d, got %0d", want.interval_start, rif.interval_start);
          n_fail++;
        end
        if (rif.interval_end !== want.interval_end) begin
          $error("interval_end: expected %0d, got %0d", want.interval_end, rif.interval_end);
          n_fail++;
        end
        if (rif.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rif.last);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sample_t               b;
    logic [DEPTH_BITS-1:0] phase_cut;
    int                    phase_len;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    sif.valid         = 1'b0;
    sif.command       = CMD_SAMPLE;
    sif.sequence_id   = '0;
    sif.position      = '0;
    sif.depth_forward = '0;
    sif.depth_reverse = '0;
    rif.ready         = 1'b0;
    run_lo            = '{default: '0};
    run_hi            = '{default: '0};
    open_seq          = '0;
    depth_cut         = CUTOFF_RESET;
    gen_pos           = '0;
    gen_seq           = '0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    src_bursty        = 1'b0;
    src_mode_left     = 0;
    stall_left        = 0;
    burst_left        = 0;
    sink_mode_left    = 0;
    sink_bursty       = 1'b0;
    n_fail            = 0;
    n_beats           = 0;
    n_flush           = 0;
    n_cutoffs         = 0;
    n_intervals       = 0;

    // Reset cutoff of 1: flush on empty runs, position zero, equal-to-cutoff extension,
    // low-depth close, out-of-order and gap closes, sequence change, field extremes.
    add_beat(CMD_FLUSH, '0, '0, '0, '0, 0);
    add_beat(CMD_SAMPLE, '0, '0, DEPTH_MAX, DEPTH_MAX, 0);
    add_beat(CMD_SAMPLE, '0, 1, 5, 5, 0);
    add_beat(CMD_SAMPLE, '0, 2, 1, 5, 0);
    add_beat(CMD_SAMPLE, '0, 3, 0, 2, 1, mk_iv('0, STRAND_FWD, 0, 2, 1'b1));
    add_beat(CMD_SAMPLE, '0, 3, 5, 5, 1, mk_iv('0, STRAND_REV, 0, 3, 1'b1));
    add_beat(CMD_SAMPLE, '0, 10, 5, 5, 2, mk_iv('0, STRAND_FWD, 2, 3, 1'b0),
             mk_iv('0, STRAND_REV, 2, 3, 1'b1));
    add_beat(CMD_SAMPLE, 7, 11, 5, 5, 2, mk_iv('0, STRAND_FWD, 9, 10, 1'b0),
             mk_iv('0, STRAND_REV, 9, 10, 1'b1));
    add_beat(CMD_SAMPLE, 7, 12, 1, 1, 0);
    add_beat(CMD_SAMPLE, 7, 12, 2, 0, 1, mk_iv(7, STRAND_REV, 10, 11, 1'b1));
    add_beat(CMD_FLUSH, '0, '0, '0, '0, 1, mk_iv(7, STRAND_FWD, 10, 12, 1'b1));
    add_beat(CMD_FLUSH, 16'hFFFF, POS_MAX, DEPTH_MAX, DEPTH_MAX, 0);
    add_beat(CMD_SAMPLE, 16'hFFFF, POS_MAX, DEPTH_MAX, DEPTH_MAX, 0);
    add_beat(CMD_FLUSH, '0, '0, '0, '0, 2,
             mk_iv(16'hFFFF, STRAND_FWD, POS_MAX - 1'b1, POS_MAX, 1'b0),
             mk_iv(16'hFFFF, STRAND_REV, POS_MAX - 1'b1, POS_MAX, 1'b1));
    add_beat(CMD_SAMPLE, '0, 5, 0, 0, 0);
    add_cutoff('0);
    add_beat(CMD_SAMPLE, 3, 1, 1, 0);
    add_beat(CMD_SAMPLE, 3, 2, 0, 0, 0);
    add_beat(CMD_SAMPLE, 3, 2, 0, 1);
    add_beat(CMD_FLUSH, '0, '0, '0, '0);
    add_cutoff(DEPTH_MAX);
    add_beat(CMD_SAMPLE, 3, 3, DEPTH_MAX, DEPTH_MAX, 0);
    add_beat(CMD_FLUSH, '0, '0, '0, '0, 0);
    add_cutoff(DEPTH_MAX - 1);
    add_beat(CMD_SAMPLE, 3, 4, DEPTH_MAX, DEPTH_MAX - 1);
    add_beat(CMD_SAMPLE, 3, 5, DEPTH_MAX - 2, DEPTH_MAX);
    add_beat(CMD_FLUSH, '0, '0, '0, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CUTOFF) begin
        set_cutoff(rows[i].cutoff);
      end else begin
        send_beat(rows[i].beat, rows[i].n_typed, rows[i].exp0, rows[i].exp1);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       phase_cut = CUTOFF_RESET;
        1:       phase_cut = '0;
        2:       phase_cut = DEPTH_BITS'($urandom_range(2, 40));
        3:       phase_cut = DEPTH_MAX;
        4:       phase_cut = DEPTH_BITS'($urandom());
        5:       phase_cut = DEPTH_BITS'($urandom_range(2, 1000));
        6:       phase_cut = DEPTH_MAX - 1;
        default: phase_cut = CUTOFF_RESET;
      endcase
      set_cutoff(phase_cut);
      calm      = (p == 7);
      phase_len = (p == 3) ? 30 : 145;
      for (int i = 0; i < phase_len; i++) begin
        // Stall the result side for a long stretch while beats keep coming.
        if (p == 1 && i == 20) hold_req = 1'b1;
        if (p == 2 && i == 70) drain(1'b0);
        b = random_beat();
        send_beat(b, -1, '0, '0);
      end
    end

    drain(1'b1);
    $display("Sent %0d beats (%0d flushes) under %0d cutoff settings.",
             n_beats, n_flush, n_cutoffs);
    $display("Checked %0d intervals, %0d mismatches.", n_intervals, n_fail);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dric_pkg.sv
rtl/dric_sample_if.sv
rtl/dric_interval_if.sv
rtl/depth_run_interval_caller_core.sv
tb/tb_depth_run_interval_caller_core.sv
